[src/sbr_pkg.sv]
// Shared types and defaults for the stream byte reassembler.
package sbr_pkg;

	localparam int CAPACITY_DEF = 64;

	typedef struct packed {
		logic [31:0] byte_index;
		logic [7:0]  byte_value;
		logic        has_byte;
		logic        ends_stream;
		logic [6:0]  window_size;
	} in_beat_t;

	typedef struct packed {
		logic       data_valid;
		logic [7:0] out_byte;
		logic       run_last;
		logic [6:0] pending_count;
		logic       stream_closed;
	} out_beat_t;

endpackage

[src/stream_byte_reassembler_unit.sv]
// Top level of the stream byte reassembler: ring store, scan and release sequencer.
//
// Usage: the source offers one beat on src_valid/src_beat (a byte or only an end
// mark, its 32-bit stream index and the free window); a beat is taken when
// src_valid is high and src_stall is low. src_stall is high from acceptance until
// every result of that beat has entered the output register, so one beat is
// handled at a time. Results leave on dst_valid/dst_beat and are taken when
// dst_stall is low; the output register holds a stalled result unchanged.
// Sequence for a beat: apply it to the ring, scan the contiguous run at the head,
// settle the pending count and closed flag, then for each released byte read the
// byte memory and then load the output register; when nothing is released, one
// result without a byte is loaded. The scan walks the valid bits slot by slot, and
// the byte memory has a single read port. A stall on the output side holds the
// sequencer in its load step. Reset clears the valid bits, indexes, count and
// flags at once; the byte memory is not cleared, since a slot is read only after
// it was written.
module stream_byte_reassembler_unit #(
	parameter int CAPACITY = sbr_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  sbr_pkg::in_beat_t src_beat,
	output logic              dst_valid,
	input  logic              dst_stall,
	output sbr_pkg::out_beat_t dst_beat
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
	localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_APPLY = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_WAIT  = 3'd5;
	localparam logic [2:0] ST_EMPTY = 3'd6;

	logic [2:0]          state_q;
	sbr_pkg::in_beat_t   beat_q;
	logic [CAPACITY-1:0] valid_q;
	logic [SW-1:0]       head_q;
	logic [SW-1:0]       scan_ptr_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       held_q;
	logic [31:0]         next_q;
	logic                end_known_q;
	logic [31:0]         end_pos_q;
	logic                closed_q;
	logic [7:0]          byte_mem [CAPACITY];
	logic [7:0]          rd_data_q;
	sbr_pkg::out_beat_t  out_q;
	logic                out_valid_q;

	logic [6:0]          win7;
	logic [CW-1:0]       win_c;
	logic [31:0]         ins_off;
	logic                ins_ok;
	logic [SW:0]         ins_sum;
	logic [SW-1:0]       ins_slot;
	logic [CAPACITY-1:0] keep;
	logic [CW-1:0]       pop_sum;
	logic [31:0]         next_run;
	logic                out_free;
	logic                out_load;

	// sign of the distance from the end index; set means the end is still ahead
	function automatic logic next_run_minus_end(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return diff[31];
	endfunction

	sbr_popcount #(.N(CAPACITY)) u_popcount (
		.clk   (clk),
		.bits  (valid_q),
		.count (pop_sum)
	);

	// clamp the window to the ring size
	assign win7  = (beat_q.window_size > 7'(CAPACITY)) ? 7'(CAPACITY) : beat_q.window_size;
	assign win_c = CW'(win7);

	assign ins_off  = beat_q.byte_index - next_q;
	assign ins_ok   = beat_q.has_byte && (ins_off < 32'(win7));
	assign ins_sum  = (SW+1)'(head_q) + (SW+1)'(ins_off[SW-1:0]);
	assign ins_slot = (ins_sum >= (SW+1)'(CAPACITY)) ? SW'(ins_sum - (SW+1)'(CAPACITY))
	                                                 : SW'(ins_sum);

	// keep only slots whose offset from the head stays inside the window
	always_comb begin
		logic [CW:0] off;
		for (int s = 0; s < CAPACITY; s++) begin
			if (SW'(s) >= head_q) begin
				off = (CW+1)'(s) - (CW+1)'(head_q);
			end else begin
				off = (CW+1)'(s) + (CW+1)'(CAPACITY) - (CW+1)'(head_q);
			end
			keep[s] = (off < (CW+1)'(win_c));
		end
	end

	assign next_run  = next_q + 32'(cnt_q);
	assign src_stall = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !dst_stall;
	assign out_load  = ((state_q == ST_WAIT) || (state_q == ST_EMPTY)) && out_free;
	assign dst_valid = out_valid_q;
	assign dst_beat  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			head_q      <= '0;
			scan_ptr_q  <= '0;
			cnt_q       <= '0;
			held_q      <= '0;
			next_q      <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
			closed_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (src_valid) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					cnt_q      <= '0;
					scan_ptr_q <= head_q;
					if (closed_q) begin
						state_q <= ST_FIN;
					end else begin
						for (int s = 0; s < CAPACITY; s++) begin
							valid_q[s] <= (valid_q[s] && keep[s]) ||
							              (ins_ok && (ins_slot == SW'(s)));
						end
						if (beat_q.ends_stream) begin
							end_known_q <= 1'b1;
							end_pos_q   <= beat_q.byte_index + 32'(beat_q.has_byte);
						end
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// measure the contiguous run at the head
					if ((cnt_q != CAP_C) && valid_q[scan_ptr_q]) begin
						cnt_q      <= cnt_q + 1'b1;
						scan_ptr_q <= (scan_ptr_q == LAST_SLOT) ? '0 : scan_ptr_q + 1'b1;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!closed_q) begin
						held_q   <= pop_sum - cnt_q;
						next_q   <= next_run;
						closed_q <= end_known_q && !next_run_minus_end(next_run, end_pos_q);
					end
					state_q <= (cnt_q == '0) ? ST_EMPTY : ST_READ;
				end
				ST_READ: begin
					valid_q[head_q] <= 1'b0;
					head_q          <= (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
					cnt_q           <= cnt_q - 1'b1;
					state_q         <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_free) begin
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_READ;
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && src_valid) begin
			beat_q <= src_beat;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_APPLY) && !closed_q && ins_ok) begin
			byte_mem[ins_slot] <= beat_q.byte_value;
		end
		if (state_q == ST_READ) begin
			rd_data_q <= byte_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.data_valid    <= (state_q == ST_WAIT);
			out_q.out_byte      <= (state_q == ST_WAIT) ? rd_data_q : 8'd0;
			out_q.run_last      <= (cnt_q == '0);
			out_q.pending_count <= 7'(held_q);
			out_q.stream_closed <= closed_q;
		end
	end

endmodule

[src/sbr_popcount.sv]
// Registered population count of the slot valid vector, one group stage then a sum.
module sbr_popcount #(
	parameter int N = sbr_pkg::CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic [N-1:0]             bits,
	output logic [$clog2(N+1)-1:0]   count
);

	localparam int NG   = (N + 7) / 8;
	localparam int SUMW = $clog2(N + 1);

	logic [NG*8-1:0] padded;
	logic [3:0]      grp_q [NG];

	assign padded = (NG*8)'(bits);

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_q[g] <= 4'($countones(padded[g*8 +: 8]));
		end
	end

	always_comb begin
		logic [SUMW+3:0] acc;
		acc = '0;
		for (int g = 0; g < NG; g++) begin
			acc = acc + (SUMW+4)'(grp_q[g]);
		end
		count = SUMW'(acc);
	end

endmodule
